[sv/trilinear_grid_sampler_unit_macros.svh]
// Assertion macros shared by the grid sampler modules.
`ifndef TRILINEAR_GRID_SAMPLER_UNIT_MACROS_SVH
`define TRILINEAR_GRID_SAMPLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define TGS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define TGS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TGS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TGS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[sv/tgs_pkg.sv]
// Shared types and constants of the trilinear grid sampler.
package tgs_pkg;

    localparam int POS_W     = 16;
    localparam int ADDR_W    = 16;
    localparam int IDX_W     = 8;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int Q_DEPTH   = 4;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [IDX_W-1:0]  t_idx;

endpackage

[sv/tgs_front.sv]
// Front stage: accepts items, clamps and splits sample positions, forms the y/z address part.
module tgs_front #(
    parameter int GRID_Y      = 64,
    parameter int GRID_X      = 32,
    parameter int GRID_Z      = 32,
    parameter int FRAC_BITS   = 8,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [tgs_pkg::ADDR_W-1:0]    i_cell_index,
    input  logic signed [15:0]            i_cell_value,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_z,
    output logic                          o_valid,
    input  logic                          i_full,
    output logic [1+tgs_pkg::ADDR_W+VALUE_WIDTH+tgs_pkg::IDX_W+3*FRAC_BITS-1:0] o_item
);
    import tgs_pkg::*;

    localparam int QW   = 1 + ADDR_W + VALUE_WIDTH + IDX_W + 3 * FRAC_BITS;
    localparam int HI_X = (GRID_X - 1) * (2 ** FRAC_BITS) - 1;
    localparam int HI_Y = (GRID_Y - 1) * (2 ** FRAC_BITS) - 1;
    localparam int HI_Z = (GRID_Z - 1) * (2 ** FRAC_BITS) - 1;

    logic          r_valid;
    logic          n_valid;
    logic [QW-1:0] r_item;
    logic [QW-1:0] n_item;
    logic          w_accept;
    logic          w_push;

    logic [POS_W-1:0]     w_cx;
    logic [POS_W-1:0]     w_cy;
    logic [POS_W-1:0]     w_cz;
    t_idx                 w_ix;
    t_idx                 w_iy;
    t_idx                 w_iz;
    t_addr                w_yz;
    logic signed [VALUE_WIDTH-1:0] w_value;

    // Saturate a signed position to [0, hi].
    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [POS_W-1:0] p,
                                                   input int hi);
        logic signed [31:0] w;
        w = 32'(p);
        if (w < 0) begin
            w = 0;
        end else if (w > hi) begin
            w = hi;
        end
        return POS_W'(w);
    endfunction

    assign w_push   = r_valid && !i_full;
    assign o_stall  = r_valid && i_full;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_cx    = clamp_pos(i_pos_x, HI_X);
        w_cy    = clamp_pos(i_pos_y, HI_Y);
        w_cz    = clamp_pos(i_pos_z, HI_Z);
        w_ix    = IDX_W'(w_cx >> FRAC_BITS);
        w_iy    = IDX_W'(w_cy >> FRAC_BITS);
        w_iz    = IDX_W'(w_cz >> FRAC_BITS);
        w_yz    = ADDR_W'(32'(w_iy) + GRID_Y * 32'(w_iz));
        w_value = VALUE_WIDTH'(i_cell_value);
        if (i_mode == MODE_SAMPLE) begin
            n_item = {MODE_SAMPLE, w_yz, {VALUE_WIDTH{1'b0}}, w_ix,
                      w_cx[FRAC_BITS-1:0], w_cy[FRAC_BITS-1:0], w_cz[FRAC_BITS-1:0]};
        end else begin
            n_item = {MODE_WRITE, i_cell_index, w_value, {IDX_W{1'b0}},
                      {(3 * FRAC_BITS){1'b0}}};
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[sv/tgs_fifo.sv]
// Short show-ahead queue between the front stage and the memory pipeline.
`include "trilinear_grid_sampler_unit_macros.svh"

module tgs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import tgs_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_count;
    logic [PW:0]      n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (PW + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `TGS_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > (PW + 1)'(Q_DEPTH), "queue over depth")
    `TGS_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && (r_count == '0), "pop from empty queue")
    `TGS_ASSERT(a_count_up, i_clk, i_rst_n, (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count lost a push")

endmodule

[sv/tgs_bank.sv]
// One copy of the grid store: one write port, two registered read ports.
module tgs_bank #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [tgs_pkg::ADDR_W-1:0] i_waddr,
    input  logic [VALUE_WIDTH-1:0]    i_wdata,
    input  logic                      i_re,
    input  logic [tgs_pkg::ADDR_W-1:0] i_raddr0,
    input  logic [tgs_pkg::ADDR_W-1:0] i_raddr1,
    output logic [VALUE_WIDTH-1:0]    o_rdata0,
    output logic [VALUE_WIDTH-1:0]    o_rdata1
);
    import tgs_pkg::*;

    logic [VALUE_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd0;
    logic [VALUE_WIDTH-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while the pipeline is stalled
        if (i_re) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

[sv/tgs_back.sv]
// Back pipeline: base address, eight-corner read, Y, X and Z blends, output register.
`include "trilinear_grid_sampler_unit_macros.svh"

module tgs_back #(
    parameter int GRID_X      = 32,
    parameter int GRID_Y      = 64,
    parameter int FRAC_BITS   = 8,
    parameter int VALUE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1+tgs_pkg::ADDR_W+VALUE_WIDTH+tgs_pkg::IDX_W+3*FRAC_BITS-1:0] i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_sample_value
);
    import tgs_pkg::*;

    localparam int VW      = VALUE_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int DW      = VW + 1;
    localparam int PW      = VW + F + 2;
    localparam int N_COPY  = 4;
    localparam int L_X     = 3 * F;
    localparam int L_VAL   = L_X + IDX_W;
    localparam int L_ADDR  = L_VAL + VW;
    localparam int L_MODE  = L_ADDR + ADDR_W;
    localparam t_addr OFF_Y = ADDR_W'(GRID_X);
    localparam t_addr OFF_Z = ADDR_W'(GRID_X * GRID_Y);

    // a + floor(f * (b - a) / 2^F)
    function automatic logic signed [VW-1:0] blend(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b,
                                                   input logic [F-1:0] f);
        logic signed [DW-1:0] d;
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] s;
        d = DW'(b) - DW'(a);
        p = d * $signed({1'b0, f});
        s = (p >>> F) + PW'(a);
        return VW'(s);
    endfunction

    logic en;

    logic                 w_mode;
    t_addr                w_addr;
    logic [VW-1:0]        w_value;
    t_idx                 w_x;
    t_addr                w_base;

    logic                 r_b1_valid;
    logic                 r_b1_sample;
    t_addr                r_b1_addr;
    logic [VW-1:0]        r_b1_value;
    logic [F-1:0]         r_b1_fx;
    logic [F-1:0]         r_b1_fy;
    logic [F-1:0]         r_b1_fz;
    logic                 w_we;

    logic [VW-1:0]        w_rd0 [N_COPY];
    logic [VW-1:0]        w_rd1 [N_COPY];

    logic                 r_b2_valid;
    logic [F-1:0]         r_b2_fx;
    logic [F-1:0]         r_b2_fy;
    logic [F-1:0]         r_b2_fz;

    logic                 r_b3_valid;
    logic signed [VW-1:0] r_b3_c [N_COPY];
    logic [F-1:0]         r_b3_fx;
    logic [F-1:0]         r_b3_fz;

    logic                 r_b4_valid;
    logic signed [VW-1:0] r_b4_lo;
    logic signed [VW-1:0] r_b4_hi;
    logic [F-1:0]         r_b4_fz;

    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_value;

    assign en    = !(r_out_valid && i_stall);
    assign o_pop = en && i_valid;

    assign w_mode  = i_item[L_MODE];
    assign w_addr  = i_item[L_MODE-1:L_ADDR];
    assign w_value = i_item[L_ADDR-1:L_VAL];
    assign w_x     = i_item[L_VAL-1:L_X];
    assign w_base  = ADDR_W'(32'(w_x) + GRID_X * 32'(w_addr));

    assign w_we = en && r_b1_valid && !r_b1_sample;

    for (genvar g = 0; g < N_COPY; g++) begin : g_copy
        localparam t_addr XO = ADDR_W'(g % 2);
        localparam t_addr ZO = ((g / 2) != 0) ? OFF_Z : '0;
        t_addr w_ra0;
        t_addr w_ra1;

        assign w_ra0 = r_b1_addr + XO + ZO;
        assign w_ra1 = w_ra0 + OFF_Y;

        tgs_bank #(
            .VALUE_WIDTH(VW)
        ) u_bank (
            .i_clk    (i_clk),
            .i_we     (w_we),
            .i_waddr  (r_b1_addr),
            .i_wdata  (r_b1_value),
            .i_re     (en),
            .i_raddr0 (w_ra0),
            .i_raddr1 (w_ra1),
            .o_rdata0 (w_rd0[g]),
            .o_rdata1 (w_rd1[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_b4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid  <= i_valid;
            // writes end at the store
            r_b2_valid  <= r_b1_valid && r_b1_sample;
            r_b3_valid  <= r_b2_valid;
            r_b4_valid  <= r_b3_valid;
            r_out_valid <= r_b4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_sample <= (w_mode == MODE_SAMPLE);
            r_b1_addr   <= (w_mode == MODE_SAMPLE) ? w_base : w_addr;
            r_b1_value  <= w_value;
            r_b1_fx     <= i_item[3*F-1:2*F];
            r_b1_fy     <= i_item[2*F-1:F];
            r_b1_fz     <= i_item[F-1:0];

            r_b2_fx <= r_b1_fx;
            r_b2_fy <= r_b1_fy;
            r_b2_fz <= r_b1_fz;

            for (int c = 0; c < N_COPY; c++) begin
                r_b3_c[c] <= blend($signed(w_rd0[c]), $signed(w_rd1[c]), r_b2_fy);
            end
            r_b3_fx <= r_b2_fx;
            r_b3_fz <= r_b2_fz;

            r_b4_lo <= blend(r_b3_c[0], r_b3_c[1], r_b3_fx);
            r_b4_hi <= blend(r_b3_c[2], r_b3_c[3], r_b3_fx);
            r_b4_fz <= r_b3_fz;

            r_out_value <= blend(r_b4_lo, r_b4_hi, r_b4_fz);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = 16'(r_out_value);

    `TGS_ASSERT(a_sample_out, i_clk, i_rst_n, (en && r_b4_valid) |=> r_out_valid, "sample lost at output")
    `TGS_ASSERT(a_write_silent, i_clk, i_rst_n, (en && r_b1_valid && !r_b1_sample) |=> !r_b2_valid, "write item made a result")
    `TGS_ASSERT(a_hold_pipe, i_clk, i_rst_n, !en |=> ($stable(r_b4_valid) && $stable(r_b1_valid)), "pipeline moved while blocked")

endmodule

[sv/trilinear_grid_sampler_unit.sv]
// Top level of the trilinear grid sampler.
//
// Input channel (i_valid / o_stall): an item with i_mode = 0 writes i_cell_value
// into the grid cell at flat index i_cell_index (x fastest, then y, then z) and
// gives no result. An item with i_mode = 1 samples the grid at the signed
// fixed-point position i_pos_x/y/z (FRAC_BITS fraction bits, grid units); each
// coordinate is clamped into the grid and the eight surrounding cells are
// blended along Y, then X, then Z.
// Output channel (o_valid / i_stall): one o_sample_value per sample item, in order.
// Throughput: one item per cycle while the receiver does not stall; four copies
// of the 64K-entry store, each with two read ports, give all eight corners at once.
// A write is seen by every sample accepted after it.
// When the receiver stalls a valid result, the result holds and the pipeline freezes;
// the four-entry queue behind the front stage fills, then o_stall rises.
// Reset clears the pipeline and the queue; the store contents stay undefined until
// written.
module trilinear_grid_sampler_unit #(
    parameter int GRID_X      = 32,
    parameter int GRID_Y      = 64,
    parameter int GRID_Z      = 32,
    parameter int FRAC_BITS   = 8,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic [tgs_pkg::ADDR_W-1:0]       i_cell_index,
    input  logic signed [15:0]               i_cell_value,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [15:0]               o_sample_value
);
    import tgs_pkg::*;

    localparam int QW = 1 + ADDR_W + VALUE_WIDTH + IDX_W + 3 * FRAC_BITS;

    logic          w_f_valid;
    logic [QW-1:0] w_f_item;
    logic          w_q_full;
    logic          w_q_valid;
    logic [QW-1:0] w_q_item;
    logic          w_q_pop;

    tgs_front #(
        .GRID_Y      (GRID_Y),
        .GRID_X      (GRID_X),
        .GRID_Z      (GRID_Z),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_cell_index (i_cell_index),
        .i_cell_value (i_cell_value),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .o_valid      (w_f_valid),
        .i_full       (w_q_full),
        .o_item       (w_f_item)
    );

    tgs_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_full  (w_q_full),
        .i_data  (w_f_item),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_item)
    );

    tgs_back #(
        .GRID_X      (GRID_X),
        .GRID_Y      (GRID_Y),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_item         (w_q_item),
        .o_pop          (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_value (o_sample_value)
    );

endmodule

[test/tgs_sample_checker.sv]
// Checker for the grid sampler: mirrors the grid, predicts each sample and compares results.
module tgs_sample_checker #(
    parameter int GRID_X    = 32,
    parameter int GRID_Y    = 64,
    parameter int GRID_Z    = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_mode,
    input  logic [tgs_pkg::ADDR_W-1:0]       i_cell_index,
    input  logic signed [15:0]               i_cell_value,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [tgs_pkg::POS_W-1:0] i_pos_z,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [15:0]               i_sample_value,
    output int                               o_fail_count,
    output int                               o_pending
);

    import tgs_pkg::*;

    logic signed [15:0] grid_copy [0:MEM_DEPTH-1];
    logic signed [15:0] expected_samples [$];

    // Saturate one coordinate into the grid, then split into cell and fraction.
    function automatic void clamp_axis(input logic signed [POS_W-1:0] raw, input int cells,
                                       output int cell_no, output longint frac);
        longint p;
        longint pos_max;
        p = longint'(raw);
        pos_max = longint'(cells - 1) * (longint'(1) << FRAC_BITS) - 1;
        if (p < 0) begin
            p = 0;
        end
        if (p > pos_max) begin
            p = pos_max;
        end
        cell_no = int'(p >>> FRAC_BITS);
        frac = p & ((longint'(1) << FRAC_BITS) - 1);
    endfunction

    function automatic longint corner(int x, int y, int z);
        int unsigned addr;
        addr = x + GRID_X * (y + GRID_Y * z);
        return longint'(grid_copy[addr % MEM_DEPTH]);
    endfunction

    // Floor shift: >>> on a signed longint rounds toward minus infinity.
    function automatic longint lerp(longint a, longint b, longint frac);
        return a + ((frac * (b - a)) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] predict_blend(logic signed [POS_W-1:0] px,
                                                          logic signed [POS_W-1:0] py,
                                                          logic signed [POS_W-1:0] pz);
        int     cx, cy, cz;
        longint fx, fy, fz;
        longint y00, y10, y01, y11, xz0, xz1, r;
        clamp_axis(px, GRID_X, cx, fx);
        clamp_axis(py, GRID_Y, cy, fy);
        clamp_axis(pz, GRID_Z, cz, fz);
        // Blend along y first, then x, then z.
        y00 = lerp(corner(cx, cy, cz), corner(cx, cy + 1, cz), fy);
        y10 = lerp(corner(cx + 1, cy, cz), corner(cx + 1, cy + 1, cz), fy);
        y01 = lerp(corner(cx, cy, cz + 1), corner(cx, cy + 1, cz + 1), fy);
        y11 = lerp(corner(cx + 1, cy, cz + 1), corner(cx + 1, cy + 1, cz + 1), fy);
        xz0 = lerp(y00, y10, fx);
        xz1 = lerp(y01, y11, fx);
        r = lerp(xz0, xz1, fz);
        return r[15:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [15:0] want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            // Retire the result before taking a new item, so one edge never pairs them.
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result %0d arrived with no sample outstanding",
                             $time, i_sample_value);
                end else begin
                    want = expected_samples.pop_front();
                    if (want !== i_sample_value) begin
                        o_fail_count++;
                        $display("%0t: sample_value expected %0d, got %0d",
                                 $time, want, i_sample_value);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_WRITE) begin
                    grid_copy[i_cell_index] = i_cell_value;
                end else begin
                    expected_samples.insert(expected_samples.size(),
                                            predict_blend(i_pos_x, i_pos_y, i_pos_z));
                end
            end
            o_pending = expected_samples.size();
        end
    end

endmodule

[test/trilinear_grid_sampler_unit_tb.sv]
// Testbench top for the trilinear grid sampler: stimulus, receiver, watchdog and verdict.
module trilinear_grid_sampler_unit_tb;

    import tgs_pkg::*;

    localparam int GRID_X         = 32;
    localparam int GRID_Y         = 64;
    localparam int GRID_Z         = 32;
    localparam int FRAC_BITS      = 8;
    localparam int ITEM_TARGET    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_mode;
    logic [ADDR_W-1:0]         i_cell_index;
    logic signed [15:0]        i_cell_value;
    logic signed [POS_W-1:0]   i_pos_x;
    logic signed [POS_W-1:0]   i_pos_y;
    logic signed [POS_W-1:0]   i_pos_z;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [15:0]        o_sample_value;

    int fail_count;
    int pending;
    int items_sent;
    int n_writes;
    int n_samples;
    int n_clamped;
    int quiet_cycles;
    bit tx_calm;
    bit rx_calm;
    bit hold_req;
    bit cell_written [0:MEM_DEPTH-1];

    trilinear_grid_sampler_unit #(
        .GRID_X      (GRID_X),
        .GRID_Y      (GRID_Y),
        .GRID_Z      (GRID_Z),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (16)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_cell_index   (i_cell_index),
        .i_cell_value   (i_cell_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_value (o_sample_value)
    );

    tgs_sample_checker #(
        .GRID_X    (GRID_X),
        .GRID_Y    (GRID_Y),
        .GRID_Z    (GRID_Z),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_cell_index   (i_cell_index),
        .i_cell_value   (i_cell_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_sample_value (o_sample_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // End the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: stall at random before results, now and then hold off for a long stretch.
    initial begin : receiver
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end else if (rx_calm) begin
                n = 0;
            end else begin
                n = $urandom_range(0, 19);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
            if ($urandom_range(0, 49) == 0) begin
                rx_calm = !rx_calm;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] flat_index(int x, int y, int z);
        return ADDR_W'(x + GRID_X * (y + GRID_Y * z));
    endfunction

    function automatic int pos_limit(int cells);
        return (cells - 1) * (1 << FRAC_BITS) - 1;
    endfunction

    // Lower corner cell of the cube that a clamped coordinate falls in.
    function automatic int base_cell(logic signed [POS_W-1:0] p, int cells);
        if (p < 0) begin
            return 0;
        end
        if (int'(p) > pos_limit(cells)) begin
            return cells - 2;
        end
        return int'(p) >>> FRAC_BITS;
    endfunction

    function automatic bit out_of_grid(logic signed [POS_W-1:0] p, int cells);
        return p < 0 || int'(p) > pos_limit(cells);
    endfunction

    function automatic logic signed [15:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int draw_frac();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return (1 << FRAC_BITS) - 1;
            default: return $urandom_range(0, (1 << FRAC_BITS) - 1);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] boundary_pos(int cells);
        case ($urandom_range(0, 6))
            0:       return 16'sh8000;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            4:       return POS_W'(pos_limit(cells));
            5:       return POS_W'(pos_limit(cells) + 1);
            default: return 16'sh7FFF;
        endcase
    endfunction

    // Offer one item at the falling edge and hold it until the block takes it.
    task automatic send_item(input logic mode, input logic [ADDR_W-1:0] idx,
                             input logic signed [15:0] value, input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py, input logic signed [POS_W-1:0] pz);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_cell_index <= idx;
        i_cell_value <= value;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_cell(input logic [ADDR_W-1:0] addr, input logic signed [15:0] value);
        // Positions are ignored on a write: fill them with noise.
        send_item(MODE_WRITE, addr, value, 16'($urandom), 16'($urandom), 16'($urandom));
        cell_written[addr] = 1'b1;
        n_writes++;
    endtask

    // Sample only once all eight corners of the clamped cube hold a written value.
    task automatic sample_at(input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
                             input logic signed [POS_W-1:0] pz);
        int bx, by, bz, c;
        logic [ADDR_W-1:0] addr;
        bx = base_cell(px, GRID_X);
        by = base_cell(py, GRID_Y);
        bz = base_cell(pz, GRID_Z);
        for (c = 0; c < 8; c++) begin
            addr = flat_index(bx + (c & 1), by + ((c >> 1) & 1), bz + ((c >> 2) & 1));
            if (!cell_written[addr]) begin
                write_cell(addr, draw_value());
            end
        end
        send_item(MODE_SAMPLE, 16'($urandom), 16'($urandom), px, py, pz);
        n_samples++;
        if (out_of_grid(px, GRID_X) || out_of_grid(py, GRID_Y) || out_of_grid(pz, GRID_Z)) begin
            n_clamped++;
        end
    endtask

    initial begin : stimulus
        int hot_x [8];
        int hot_y [8];
        int hot_z [8];
        int c, k, pick, reps, bx, by, bz;
        bit pressure_done;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = MODE_WRITE;
        i_cell_index = '0;
        i_cell_value = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        pressure_done = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Origin cube with alternating extremes, so every blend step sees the widest span.
        for (c = 0; c < 8; c++) begin
            write_cell(flat_index(c & 1, (c >> 1) & 1, (c >> 2) & 1),
                       ((c ^ (c >> 1) ^ (c >> 2)) & 1) ? 16'sh7FFF : 16'sh8000);
        end
        sample_at(16'sd0, 16'sd0, 16'sd0);
        sample_at(16'sd255, 16'sd255, 16'sd255);
        sample_at(16'sh8000, 16'sh8000, 16'sh8000);
        sample_at(-16'sd1, 16'sd128, 16'sd77);
        sample_at(16'sd128, -16'sd5, 16'sd255);
        // Far corner of the grid: saturate above, sit exactly on the limit, step just past it.
        sample_at(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        sample_at(POS_W'(pos_limit(GRID_X)), POS_W'(pos_limit(GRID_Y)),
                  POS_W'(pos_limit(GRID_Z)));
        sample_at(POS_W'(pos_limit(GRID_X) + 1), POS_W'(pos_limit(GRID_Y) + 1),
                  POS_W'(pos_limit(GRID_Z) + 1));

        for (k = 0; k < 8; k++) begin
            hot_x[k] = $urandom_range(0, GRID_X - 2);
            hot_y[k] = $urandom_range(0, GRID_Y - 2);
            hot_z[k] = $urandom_range(0, GRID_Z - 2);
        end

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // A cube filled once, then sampled a few times, with the odd corner rewrite.
                if ($urandom_range(0, 1)) begin
                    k = $urandom_range(0, 7);
                    bx = hot_x[k];
                    by = hot_y[k];
                    bz = hot_z[k];
                end else begin
                    bx = $urandom_range(0, GRID_X - 2);
                    by = $urandom_range(0, GRID_Y - 2);
                    bz = $urandom_range(0, GRID_Z - 2);
                end
                reps = $urandom_range(1, 6);
                repeat (reps) begin
                    if ($urandom_range(0, 9) == 0) begin
                        write_cell(flat_index(bx + $urandom_range(0, 1), by + $urandom_range(0, 1),
                                              bz + $urandom_range(0, 1)), draw_value());
                    end
                    sample_at(POS_W'((bx << FRAC_BITS) | draw_frac()),
                              POS_W'((by << FRAC_BITS) | draw_frac()),
                              POS_W'((bz << FRAC_BITS) | draw_frac()));
                end
            end else if (pick < 80) begin
                sample_at(16'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick < 95) begin
                write_cell(16'($urandom), draw_value());
            end else begin
                sample_at(boundary_pos(GRID_X), boundary_pos(GRID_Y), boundary_pos(GRID_Z));
            end

            if ($urandom_range(0, 29) == 0) begin
                tx_calm = !tx_calm;
            end

            if (!pressure_done && items_sent >= ITEM_TARGET / 2) begin
                // Drain fully, then flood the block while the receiver holds off.
                i_valid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
                hold_req = 1'b1;
                tx_calm = 1'b1;
                repeat (40) begin
                    sample_at(POS_W'((hot_x[0] << FRAC_BITS) | draw_frac()),
                              POS_W'((hot_y[0] << FRAC_BITS) | draw_frac()),
                              POS_W'((hot_z[0] << FRAC_BITS) | draw_frac()));
                end
                tx_calm = 1'b0;
                pressure_done = 1'b1;
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Covered %0d cell writes and %0d samples, %0d of them clamped on some axis,",
                 n_writes, n_samples, n_clamped);
        $display("with random gaps and stalls, one long output hold-off and one full drain.");
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[trilinear_grid_sampler_unit.f]
+incdir+sv
sv/tgs_pkg.sv
sv/tgs_front.sv
sv/tgs_fifo.sv
sv/tgs_bank.sv
sv/tgs_back.sv
sv/trilinear_grid_sampler_unit.sv
test/tgs_sample_checker.sv
test/trilinear_grid_sampler_unit_tb.sv
